// File: src/rwhd_pkg.sv
// ----------------------------------------------------------------------------
// rwhd_pkg
// Shared widths, node and slot layouts and control structs for the
// rank-weight Huffman decoder.
// ----------------------------------------------------------------------------
package rwhd_pkg;

  localparam int MAX_SYMBOLS = 64;
  localparam int NODE_COUNT  = 2 * MAX_SYMBOLS - 1;
  localparam int SYM_W       = 6;
  localparam int NODE_W      = 7;
  localparam int CNT_W       = 7;
  localparam int WEIGHT_W    = 12;
  localparam int LEN_W       = 6;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;

  localparam logic [CNT_W-1:0] COUNT_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_SYMBOLS);

  localparam logic REG_SYMBOL_COUNT = 1'b0;

  typedef struct packed {
    logic              leaf;
    logic [SYM_W-1:0]  symbol;
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
  } node_entry_t;

  typedef struct packed {
    logic                en;
    logic [NODE_W-1:0]   addr;
    node_entry_t         entry;
  } node_wr_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [NODE_W-1:0]   node;
  } slot_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
  } cfg_ctl_t;

  typedef struct packed {
    logic        built;
    logic        load;
    node_entry_t root;
  } tree_ctl_t;

endpackage

// File: src/rwhd_in_if.sv
// ----------------------------------------------------------------------------
// rwhd_in_if
// Code bit channel: valid/ready transfer of one code bit.
// ----------------------------------------------------------------------------
interface rwhd_in_if;
  logic valid;
  logic ready;
  logic code_bit;

  modport source (output valid, output code_bit, input ready);
  modport sink (input valid, input code_bit, output ready);
endinterface

// File: src/rwhd_out_if.sv
// ----------------------------------------------------------------------------
// rwhd_out_if
// Result channel: valid/ready transfer of a decoded symbol and its length.
// ----------------------------------------------------------------------------
interface rwhd_out_if;
  logic                      valid;
  logic                      ready;
  logic [rwhd_pkg::SYM_W-1:0] symbol;
  logic [rwhd_pkg::LEN_W-1:0] code_length;

  modport source (output valid, output symbol, output code_length, input ready);
  modport sink (input valid, input symbol, input code_length, output ready);
endinterface

// File: src/rwhd_cfg.sv
// ----------------------------------------------------------------------------
// rwhd_cfg
// APB-style register port holding symbol_count; a write clamps the value
// and starts a tree rebuild.
// ----------------------------------------------------------------------------
module rwhd_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rwhd_pkg::ADDR_W-1:0] paddr,
  input  logic [rwhd_pkg::DATA_W-1:0] pwdata,
  output logic [rwhd_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output rwhd_pkg::cfg_ctl_t          ctl
);

  logic [rwhd_pkg::CNT_W-1:0] count_r;
  logic [rwhd_pkg::CNT_W-1:0] count_nxt;
  logic                       start_r;
  logic                       wr_hit;
  logic [rwhd_pkg::CNT_W-1:0] wval;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == rwhd_pkg::REG_SYMBOL_COUNT);
  assign wval   = pwdata[rwhd_pkg::CNT_W-1:0];

  always_comb begin
    priority if (wval < rwhd_pkg::COUNT_MIN) begin
      count_nxt = rwhd_pkg::COUNT_MIN;
    end else if (wval > rwhd_pkg::COUNT_MAX) begin
      count_nxt = rwhd_pkg::COUNT_MAX;
    end else begin
      count_nxt = wval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= rwhd_pkg::COUNT_MIN;
      start_r <= 1'b0;
    end else begin
      start_r <= wr_hit;
      if (wr_hit) begin
        count_r <= count_nxt;
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == rwhd_pkg::REG_SYMBOL_COUNT) begin
      prdata = rwhd_pkg::DATA_W'(count_r);
    end
  end

  assign ctl.start = start_r;
  assign ctl.count = count_r;

endmodule

// File: src/rwhd_builder.sv
// ----------------------------------------------------------------------------
// rwhd_builder
// Tree build sequencer: loads leaf slots, then per merge scans the slot
// memory for the two lightest live slots and writes one inner node.
// ----------------------------------------------------------------------------
module rwhd_builder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rwhd_pkg::cfg_ctl_t   ctl,
  output rwhd_pkg::node_wr_t   node_wr,
  output rwhd_pkg::tree_ctl_t  tree
);

  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam int IDX_W = $clog2(rwhd_pkg::MAX_SYMBOLS);

  logic [1:0]                        state_r;
  logic [rwhd_pkg::CNT_W-1:0]        idx_r;
  logic [rwhd_pkg::CNT_W-1:0]        merges_r;
  logic [rwhd_pkg::NODE_W-1:0]       next_r;
  logic [rwhd_pkg::MAX_SYMBOLS-1:0]  live_r;
  logic                              rd_vld_r;
  logic [IDX_W-1:0]                  rd_idx_r;
  logic                              f1_r;
  logic                              f2_r;
  logic [IDX_W-1:0]                  b1_idx_r;
  logic [IDX_W-1:0]                  b2_idx_r;
  rwhd_pkg::slot_t                   b1_r;
  rwhd_pkg::slot_t                   b2_r;
  logic                              load_r;
  rwhd_pkg::node_entry_t             root_r;

  rwhd_pkg::slot_t                   slot_mem [rwhd_pkg::MAX_SYMBOLS];
  rwhd_pkg::slot_t                   rd_data_r;
  logic                              slot_we;
  logic [IDX_W-1:0]                  slot_waddr;
  rwhd_pkg::slot_t                   slot_wdata;
  logic                              slot_re;
  logic                              last_merge;
  rwhd_pkg::node_entry_t             merged;

  assign slot_re    = (state_r == ST_SCAN) && (idx_r < ctl.count);
  assign last_merge = (merges_r == (ctl.count - rwhd_pkg::CNT_W'(2)));

  always_comb begin
    merged.leaf   = 1'b0;
    merged.symbol = '0;
    merged.left   = b1_r.node;
    merged.right  = b2_r.node;
  end

  always_comb begin
    slot_we           = 1'b0;
    slot_waddr        = idx_r[IDX_W-1:0];
    slot_wdata.weight = rwhd_pkg::WEIGHT_W'(idx_r) + rwhd_pkg::WEIGHT_W'(1);
    slot_wdata.node   = rwhd_pkg::NODE_W'(idx_r);
    node_wr.en           = 1'b0;
    node_wr.addr         = rwhd_pkg::NODE_W'(idx_r);
    node_wr.entry.leaf   = 1'b1;
    node_wr.entry.symbol = idx_r[rwhd_pkg::SYM_W-1:0];
    node_wr.entry.left   = '0;
    node_wr.entry.right  = '0;
    unique case (state_r)
      ST_INIT: begin
        slot_we    = 1'b1;
        node_wr.en = 1'b1;
      end
      ST_MERGE: begin
        slot_we           = 1'b1;
        slot_waddr        = b1_idx_r;
        slot_wdata.weight = b1_r.weight + b2_r.weight;
        slot_wdata.node   = next_r;
        node_wr.en        = 1'b1;
        node_wr.addr      = next_r;
        node_wr.entry     = merged;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      rd_data_r <= slot_mem[idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.start) begin
      state_r  <= ST_INIT;
      idx_r    <= '0;
      merges_r <= '0;
      next_r   <= '0;
      live_r   <= '1;
      rd_vld_r <= 1'b0;
      f1_r     <= 1'b0;
      f2_r     <= 1'b0;
      load_r   <= 1'b0;
    end else begin
      load_r   <= 1'b0;
      rd_vld_r <= slot_re;
      rd_idx_r <= idx_r[IDX_W-1:0];
      unique case (state_r)
        ST_INIT: begin
          if (idx_r == ctl.count - rwhd_pkg::CNT_W'(1)) begin
            state_r <= ST_SCAN;
            idx_r   <= '0;
            next_r  <= rwhd_pkg::NODE_W'(ctl.count);
            f1_r    <= 1'b0;
            f2_r    <= 1'b0;
          end else begin
            idx_r <= idx_r + rwhd_pkg::CNT_W'(1);
          end
        end
        ST_SCAN: begin
          if (slot_re) begin
            idx_r <= idx_r + rwhd_pkg::CNT_W'(1);
          end
          if (rd_vld_r && live_r[rd_idx_r]) begin
            priority if (!f1_r || (rd_data_r.weight < b1_r.weight)) begin
              f1_r     <= 1'b1;
              b1_idx_r <= rd_idx_r;
              b1_r     <= rd_data_r;
              f2_r     <= f1_r;
              b2_idx_r <= b1_idx_r;
              b2_r     <= b1_r;
            end else if (!f2_r || (rd_data_r.weight < b2_r.weight)) begin
              f2_r     <= 1'b1;
              b2_idx_r <= rd_idx_r;
              b2_r     <= rd_data_r;
            end else begin
            end
          end
          if (!slot_re && !rd_vld_r) begin
            state_r <= ST_MERGE;
          end
        end
        ST_MERGE: begin
          live_r[b2_idx_r] <= 1'b0;
          next_r           <= next_r + rwhd_pkg::NODE_W'(1);
          merges_r         <= merges_r + rwhd_pkg::CNT_W'(1);
          idx_r            <= '0;
          f1_r             <= 1'b0;
          f2_r             <= 1'b0;
          if (last_merge) begin
            state_r <= ST_DONE;
            load_r  <= 1'b1;
            root_r  <= merged;
          end else begin
            state_r <= ST_SCAN;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // hold off code bits while the root loads and while a rebuild is pending
  assign tree.built = (state_r == ST_DONE) && !load_r && !ctl.start;
  assign tree.load  = load_r;
  assign tree.root  = root_r;

  a_merge_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> (f1_r && f2_r && (b1_idx_r != b2_idx_r)))
    else $error("merge without two distinct live slots");

  a_node_range: assert property (@(posedge clk) disable iff (!rst_n)
    node_wr.en |-> (node_wr.addr < rwhd_pkg::NODE_W'(rwhd_pkg::NODE_COUNT)))
    else $error("node write beyond table");

  a_load_done: assert property (@(posedge clk) disable iff (!rst_n || ctl.start)
    load_r |-> (state_r == ST_DONE))
    else $error("root load outside completed build");

endmodule

// File: src/rwhd_walker.sv
// ----------------------------------------------------------------------------
// rwhd_walker
// Node table and tree walk: one node read per code bit, result register on
// reaching a leaf, return to the root.
// ----------------------------------------------------------------------------
module rwhd_walker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rwhd_pkg::node_wr_t   node_wr,
  input  rwhd_pkg::tree_ctl_t  tree,
  rwhd_in_if.sink              in_ch,
  rwhd_out_if.source           out_ch
);

  rwhd_pkg::node_entry_t        node_mem [rwhd_pkg::NODE_COUNT];
  rwhd_pkg::node_entry_t        rd_q;
  rwhd_pkg::node_entry_t        cur_r;
  rwhd_pkg::node_entry_t        root_r;
  rwhd_pkg::node_entry_t        eff;
  logic [rwhd_pkg::LEN_W-1:0]   depth_r;
  logic [rwhd_pkg::LEN_W-1:0]   pend_depth_r;
  logic [rwhd_pkg::LEN_W-1:0]   depth_eff;
  logic                         busy_r;
  logic                         out_valid_r;
  logic [rwhd_pkg::SYM_W-1:0]   symbol_r;
  logic [rwhd_pkg::LEN_W-1:0]   length_r;
  logic                         out_free;
  logic                         resolve_ok;
  logic                         resolve;
  logic                         accept;
  logic [rwhd_pkg::NODE_W-1:0]  rd_addr;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign resolve_ok = !rd_q.leaf || out_free;
  assign resolve    = busy_r && resolve_ok;

  always_comb begin
    eff       = cur_r;
    depth_eff = depth_r;
    if (busy_r) begin
      if (rd_q.leaf) begin
        eff       = root_r;
        depth_eff = '0;
      end else begin
        eff       = rd_q;
        depth_eff = pend_depth_r;
      end
    end
  end

  assign in_ch.ready = tree.built && (!busy_r || resolve_ok);
  assign accept      = in_ch.valid && in_ch.ready;
  assign rd_addr     = in_ch.code_bit ? eff.right : eff.left;

  always_ff @(posedge clk) begin
    if (node_wr.en) begin
      node_mem[node_wr.addr] <= node_wr.entry;
    end
    if (accept) begin
      rd_q <= node_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      depth_r     <= '0;
    end else if (tree.load) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      depth_r     <= '0;
      cur_r       <= tree.root;
      root_r      <= tree.root;
    end else begin
      if (resolve) begin
        cur_r   <= eff;
        depth_r <= depth_eff;
      end
      if (accept) begin
        busy_r       <= 1'b1;
        pend_depth_r <= depth_eff + rwhd_pkg::LEN_W'(1);
      end else if (resolve) begin
        busy_r <= 1'b0;
      end
      if (resolve && rd_q.leaf) begin
        out_valid_r <= 1'b1;
        symbol_r    <= rd_q.symbol;
        length_r    <= pend_depth_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.symbol      = symbol_r;
  assign out_ch.code_length = length_r;

  a_accept_built: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> tree.built)
    else $error("code bit taken before tree is built");

  a_leaf_result: assert property (@(posedge clk) disable iff (!rst_n || tree.load)
    (resolve && rd_q.leaf) |=> (out_valid_r && (length_r != '0)))
    else $error("leaf reached without result");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n || tree.load)
    (busy_r && rd_q.leaf && !out_free) |=> busy_r)
    else $error("pending leaf dropped under output stall");

endmodule

// File: src/rank_weight_huffman_decoder.sv
// ----------------------------------------------------------------------------
// rank_weight_huffman_decoder
// Huffman decoder with a tree built from the symbol count (weight k+1).
// A result is registered in out_valid_r after the node read for its last bit
// is registered in rd_q; an output stall can hold it. Throughput: one code bit
// per cycle while the output is not stalled; the node-table read feeds the next
// address through a bypass of the registered read data. Reset rebuilds the
// tree, as does a symbol_count write; in_ch.ready is low until the root loads.
// ----------------------------------------------------------------------------
module rank_weight_huffman_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  rwhd_in_if.sink                     in_ch,
  rwhd_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rwhd_pkg::ADDR_W-1:0] paddr,
  input  logic [rwhd_pkg::DATA_W-1:0] pwdata,
  output logic [rwhd_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  rwhd_pkg::cfg_ctl_t  cfg_ctl;
  rwhd_pkg::node_wr_t  node_wr;
  rwhd_pkg::tree_ctl_t tree;

  rwhd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctl     (cfg_ctl)
  );

  rwhd_builder u_builder (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cfg_ctl),
    .node_wr (node_wr),
    .tree    (tree)
  );

  rwhd_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .node_wr (node_wr),
    .tree    (tree),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

endmodule
